// ===== hw/rtl/srit_pkg.sv =====
// ----------------------------------------------------------------------------
// srit_pkg
// Shared types and codes for the sorted range index table.
// ----------------------------------------------------------------------------
`default_nettype none

package srit_pkg;

  localparam logic [1:0] FUNC_ADD     = 2'd0;
  localparam logic [1:0] FUNC_CONSUME = 2'd1;
  localparam logic [1:0] FUNC_FIND    = 2'd2;
  localparam logic [1:0] FUNC_GAP     = 2'd3;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_BAD   = 2'd2;

  localparam logic [7:0] CFG_STREAM_SIZE = 8'd0;
  localparam logic [7:0] CFG_FILE_TYPE   = 8'd1;

  localparam logic [62:0] STREAM_SIZE_RST = 63'h7fffffffffffffff;
  localparam logic [7:0]  FILE_TYPE_RST   = 8'd1;

  typedef struct packed {
    logic [62:0] start;
    logic [30:0] len;
    logic [62:0] cache;
    logic [31:0] valid;
    logic [7:0]  kind;
  } entry_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [62:0] key_offset;
    logic [30:0] range_length;
    logic [62:0] cache_offset;
    logic [30:0] valid_bytes;
    logic [7:0]  range_type;
    logic [7:0]  entry_index;
    logic [30:0] consume_length;
    logic [62:0] lower_bound;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        hit;
    logic [7:0]  found_index;
    logic [62:0] found_start;
    logic [30:0] found_length;
    logic [62:0] found_cache_offset;
    logic [31:0] found_valid;
    logic [7:0]  found_type;
    logic [62:0] gap_start;
    logic [31:0] gap_size;
  } res_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LK_RD, ST_LK_CMP, ST_DISPATCH, ST_ADD_WR,
    ST_UP_RD, ST_UP_WR, ST_DN_RD, ST_DN_WR,
    ST_CS_RDP, ST_CS_RDA, ST_CS_CHK, ST_CS_NEW, ST_CS_ITEM,
    ST_FD_RD, ST_FD_CHK,
    ST_GP_RD, ST_GP_CUR, ST_GP_RDN, ST_GP_CMP, ST_GP_FIN,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/srit_mem.sv =====
// ----------------------------------------------------------------------------
// srit_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module srit_mem #(
  parameter int ENTRIES = 256
) (
  input  wire                          clk_i,
  input  wire                          re_i,
  input  wire [$clog2(ENTRIES)-1:0]    raddr_i,
  output srit_pkg::entry_t             rdata_o,
  input  wire                          we_i,
  input  wire [$clog2(ENTRIES)-1:0]    waddr_i,
  input  wire srit_pkg::entry_t        wdata_i
);

  srit_pkg::entry_t mem_q [ENTRIES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/srit_ctrl.sv =====
// ----------------------------------------------------------------------------
// srit_ctrl
// Sequencer: binary search, entry shifting and per-operation read/modify/write.
// ----------------------------------------------------------------------------
`default_nettype none

module srit_ctrl #(
  parameter int ENTRIES = 256
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire srit_pkg::req_t          req_i,
  input  wire [62:0]                   stream_size_i,
  input  wire [7:0]                    file_type_i,
  output logic                         res_valid_o,
  input  wire                          res_ready_i,
  output srit_pkg::res_t               res_o,
  output logic                         mem_re_o,
  output logic [$clog2(ENTRIES)-1:0]   mem_raddr_o,
  input  wire srit_pkg::entry_t        mem_rdata_i,
  output logic                         mem_we_o,
  output logic [$clog2(ENTRIES)-1:0]   mem_waddr_o,
  output srit_pkg::entry_t             mem_wdata_o
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int IW = (CW > 8) ? CW : 8;
  localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);
  localparam logic [CW-1:0] ONE      = CW'(1);

  srit_pkg::state_e state_q, state_d;
  srit_pkg::req_t   req_q, req_d;
  srit_pkg::res_t   res_q, res_d;
  srit_pkg::entry_t item_q, item_d, prev_q, prev_d;
  logic [CW-1:0]    count_q, count_d, lp1_q, lp1_d, hi_q, hi_d;
  logic [CW-1:0]    i_q, i_d, pos_q, pos_d, a_q, a_d;
  logic [AW-1:0]    m_q, m_d;
  logic             nxt_q, nxt_d;
  logic [62:0]      nxt_start_q, nxt_start_d;

  logic [CW:0]      msum;
  logic [AW-1:0]    m_c;
  logic [CW-1:0]    lp1_c, hi_c;
  logic [63:0]      sd, cd, nl, e_cur, gs, ge, gd;
  logic             merge_c, hit_c;
  logic [31:0]      sz_c;
  srit_pkg::entry_t upd_c, new_c;

  always_comb begin
    msum = ({1'b0, lp1_q} + {1'b0, hi_q} - {{CW{1'b0}}, 1'b1}) >> 1;
    m_c  = AW'(msum);
    lp1_c = lp1_q;
    hi_c  = hi_q;
    if (mem_rdata_i.start <= req_q.key_offset) begin
      lp1_c = CW'(m_q) + ONE;
    end
    if (mem_rdata_i.start >= req_q.key_offset) begin
      hi_c = CW'(m_q);
    end
  end

  // consume: merge test against previous entry
  always_comb begin
    sd = {1'b0, mem_rdata_i.start} - {1'b0, prev_q.start};
    cd = {1'b0, req_q.cache_offset} - {1'b0, prev_q.cache};
    merge_c = (a_q != '0) && (prev_q.kind == file_type_i) && (sd == cd) &&
              ($signed(sd) <= $signed({33'd0, prev_q.len}));
    nl = sd + {33'd0, req_q.consume_length};
    upd_c = prev_q;
    if ($signed(nl) < 0) begin
      upd_c.len   = '0;
      upd_c.valid = '0;
    end else if ($signed(nl) > $signed(64'h7fffffff)) begin
      upd_c.len   = 31'h7fffffff;
      upd_c.valid = 32'h7fffffff;
    end else begin
      upd_c.len   = nl[30:0];
      upd_c.valid = {1'b0, nl[30:0]};
    end
    new_c.start = item_q.start;
    new_c.len   = req_q.consume_length;
    new_c.cache = req_q.cache_offset;
    new_c.valid = {1'b0, req_q.consume_length};
    new_c.kind  = file_type_i;
  end

  // find and gap arithmetic
  always_comb begin
    hit_c = (mem_rdata_i.start <= req_q.key_offset) &&
            ((req_q.key_offset - mem_rdata_i.start) < {32'd0, mem_rdata_i.len});
    e_cur = {1'b0, prev_q.start} + {33'd0, prev_q.len};
    gs = {1'b0, req_q.lower_bound};
    if ((lp1_q != '0) && (e_cur > gs)) begin
      gs = e_cur;
    end
    ge = nxt_q ? {1'b0, nxt_start_q} : {1'b0, stream_size_i};
    if (ge >= gs) begin
      gd = ge - gs;
      sz_c = (gd > 64'h7fffffff) ? 32'h7fffffff : gd[31:0];
    end else begin
      gd = gs - ge;
      sz_c = (gd > 64'h80000000) ? 32'h80000000 : (32'd0 - gd[31:0]);
    end
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    res_d       = res_q;
    item_d      = item_q;
    prev_d      = prev_q;
    count_d     = count_q;
    lp1_d       = lp1_q;
    hi_d        = hi_q;
    i_d         = i_q;
    pos_d       = pos_q;
    a_d         = a_q;
    m_d         = m_q;
    nxt_d       = nxt_q;
    nxt_start_d = nxt_start_q;
    unique case (state_q)
      srit_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          req_d = req_i;
          res_d = '0;
          lp1_d = '0;
          hi_d  = count_q;
          nxt_d = 1'b0;
          a_d   = CW'(IW'(req_i.entry_index));
          if (req_i.func == srit_pkg::FUNC_CONSUME) begin
            if (IW'(req_i.entry_index) >= IW'(count_q)) begin
              res_d.status = srit_pkg::STATUS_BAD;
              state_d = srit_pkg::ST_DONE;
            end else if (req_i.entry_index != 8'd0) begin
              state_d = srit_pkg::ST_CS_RDP;
            end else begin
              state_d = srit_pkg::ST_CS_RDA;
            end
          end else if ((req_i.func == srit_pkg::FUNC_ADD) && (count_q == FULL_CNT)) begin
            res_d.status = srit_pkg::STATUS_FULL;
            state_d = srit_pkg::ST_DONE;
          end else if (count_q != '0) begin
            state_d = srit_pkg::ST_LK_RD;
          end else begin
            state_d = srit_pkg::ST_DISPATCH;
          end
        end
      end
      srit_pkg::ST_LK_RD: begin
        m_d = m_c;
        state_d = srit_pkg::ST_LK_CMP;
      end
      srit_pkg::ST_LK_CMP: begin
        lp1_d = lp1_c;
        hi_d  = hi_c;
        state_d = (hi_c > lp1_c) ? srit_pkg::ST_LK_RD : srit_pkg::ST_DISPATCH;
      end
      srit_pkg::ST_DISPATCH: begin
        a_d = lp1_q - ONE;
        case (req_q.func)
          srit_pkg::FUNC_ADD: begin
            pos_d = lp1_q;
            i_d   = count_q;
            state_d = srit_pkg::ST_UP_RD;
          end
          srit_pkg::FUNC_FIND: begin
            state_d = (lp1_q == '0) ? srit_pkg::ST_DONE : srit_pkg::ST_FD_RD;
          end
          default: begin
            state_d = (lp1_q == '0) ? srit_pkg::ST_GP_FIN : srit_pkg::ST_GP_RD;
          end
        endcase
      end
      srit_pkg::ST_UP_RD: begin
        if (i_q > pos_q) begin
          state_d = srit_pkg::ST_UP_WR;
        end else begin
          count_d = count_q + ONE;
          state_d = (req_q.func == srit_pkg::FUNC_ADD) ? srit_pkg::ST_ADD_WR
                                                       : srit_pkg::ST_CS_NEW;
        end
      end
      srit_pkg::ST_UP_WR: begin
        i_d = i_q - ONE;
        state_d = srit_pkg::ST_UP_RD;
      end
      srit_pkg::ST_ADD_WR: begin
        state_d = srit_pkg::ST_DONE;
      end
      srit_pkg::ST_CS_RDP: begin
        state_d = srit_pkg::ST_CS_RDA;
      end
      srit_pkg::ST_CS_RDA: begin
        prev_d = mem_rdata_i;
        state_d = srit_pkg::ST_CS_CHK;
      end
      srit_pkg::ST_CS_CHK: begin
        item_d = mem_rdata_i;
        if (merge_c) begin
          state_d = srit_pkg::ST_CS_ITEM;
        end else if (count_q == FULL_CNT) begin
          res_d.status = srit_pkg::STATUS_FULL;
          state_d = srit_pkg::ST_DONE;
        end else begin
          pos_d = a_q;
          i_d   = count_q;
          state_d = srit_pkg::ST_UP_RD;
        end
      end
      srit_pkg::ST_CS_NEW: begin
        a_d = a_q + ONE;
        state_d = srit_pkg::ST_CS_ITEM;
      end
      srit_pkg::ST_CS_ITEM: begin
        if (item_q.len <= req_q.consume_length) begin
          i_d = a_q;
          state_d = srit_pkg::ST_DN_RD;
        end else begin
          state_d = srit_pkg::ST_DONE;
        end
      end
      srit_pkg::ST_DN_RD: begin
        if ((i_q + ONE) < count_q) begin
          state_d = srit_pkg::ST_DN_WR;
        end else begin
          count_d = count_q - ONE;
          state_d = srit_pkg::ST_DONE;
        end
      end
      srit_pkg::ST_DN_WR: begin
        i_d = i_q + ONE;
        state_d = srit_pkg::ST_DN_RD;
      end
      srit_pkg::ST_FD_RD: begin
        state_d = srit_pkg::ST_FD_CHK;
      end
      srit_pkg::ST_FD_CHK: begin
        if (hit_c) begin
          res_d.hit                = 1'b1;
          res_d.found_index        = 8'(IW'(a_q));
          res_d.found_start        = mem_rdata_i.start;
          res_d.found_length       = mem_rdata_i.len;
          res_d.found_cache_offset = mem_rdata_i.cache;
          res_d.found_valid        = mem_rdata_i.valid;
          res_d.found_type         = mem_rdata_i.kind;
        end
        state_d = srit_pkg::ST_DONE;
      end
      srit_pkg::ST_GP_RD: begin
        state_d = srit_pkg::ST_GP_CUR;
      end
      srit_pkg::ST_GP_CUR: begin
        prev_d = mem_rdata_i;
        state_d = srit_pkg::ST_GP_RDN;
      end
      srit_pkg::ST_GP_RDN: begin
        state_d = ((a_q + ONE) < count_q) ? srit_pkg::ST_GP_CMP : srit_pkg::ST_GP_FIN;
      end
      srit_pkg::ST_GP_CMP: begin
        if (e_cur >= {1'b0, mem_rdata_i.start}) begin
          prev_d = mem_rdata_i;
          a_d = a_q + ONE;
          state_d = srit_pkg::ST_GP_RDN;
        end else begin
          nxt_d = 1'b1;
          nxt_start_d = mem_rdata_i.start;
          state_d = srit_pkg::ST_GP_FIN;
        end
      end
      srit_pkg::ST_GP_FIN: begin
        res_d.gap_start = gs[62:0];
        res_d.gap_size  = sz_c;
        state_d = srit_pkg::ST_DONE;
      end
      srit_pkg::ST_DONE: begin
        if (res_ready_i) begin
          state_d = srit_pkg::ST_IDLE;
        end
      end
      default: state_d = srit_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = mem_rdata_i;
    unique case (state_q)
      srit_pkg::ST_IDLE: in_ready_o = 1'b1;
      srit_pkg::ST_LK_RD: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = m_c;
      end
      srit_pkg::ST_UP_RD: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = AW'(i_q - ONE);
      end
      srit_pkg::ST_UP_WR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = AW'(i_q);
      end
      srit_pkg::ST_ADD_WR: begin
        mem_we_o          = 1'b1;
        mem_waddr_o       = AW'(pos_q);
        mem_wdata_o.start = req_q.key_offset;
        mem_wdata_o.len   = req_q.range_length;
        mem_wdata_o.cache = req_q.cache_offset;
        mem_wdata_o.valid = {1'b0, req_q.valid_bytes};
        mem_wdata_o.kind  = req_q.range_type;
      end
      srit_pkg::ST_CS_RDP: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = AW'(a_q - ONE);
      end
      srit_pkg::ST_CS_RDA: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = AW'(a_q);
      end
      srit_pkg::ST_CS_CHK: begin
        mem_we_o    = merge_c;
        mem_waddr_o = AW'(a_q - ONE);
        mem_wdata_o = upd_c;
      end
      srit_pkg::ST_CS_NEW: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = AW'(a_q);
        mem_wdata_o = new_c;
      end
      srit_pkg::ST_CS_ITEM: begin
        mem_we_o          = (item_q.len > req_q.consume_length);
        mem_waddr_o       = AW'(a_q);
        mem_wdata_o.start = item_q.start + {32'd0, req_q.consume_length};
        mem_wdata_o.len   = item_q.len - req_q.consume_length;
        mem_wdata_o.cache = item_q.cache + {32'd0, req_q.consume_length};
        mem_wdata_o.valid = item_q.valid - {1'b0, req_q.consume_length};
        mem_wdata_o.kind  = item_q.kind;
      end
      srit_pkg::ST_DN_RD: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = AW'(i_q + ONE);
      end
      srit_pkg::ST_DN_WR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = AW'(i_q);
      end
      srit_pkg::ST_FD_RD, srit_pkg::ST_GP_RD: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = AW'(a_q);
      end
      srit_pkg::ST_GP_RDN: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = AW'(a_q + ONE);
      end
      srit_pkg::ST_DONE: res_valid_o = 1'b1;
      default: ;
    endcase
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srit_pkg::ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    res_q       <= res_d;
    item_q      <= item_d;
    prev_q      <= prev_d;
    lp1_q       <= lp1_d;
    hi_q        <= hi_d;
    i_q         <= i_d;
    pos_q       <= pos_d;
    a_q         <= a_d;
    m_q         <= m_d;
    nxt_q       <= nxt_d;
    nxt_start_q <= nxt_start_d;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_range_index_table.sv =====
// ----------------------------------------------------------------------------
// sorted_range_index_table
// Sorted table of stream byte ranges with add, consume, find and gap words.
// ----------------------------------------------------------------------------
// One word is processed at a time; the result lands in an output register so
// the next word can be taken while it waits. Entries live in a single
// RAM with registered read data, so cost is counted in RAM accesses: each
// binary-search probe of the lookup is a read followed by a compare. Find
// adds one read and a check of the entry. Gap adds one read per contiguous
// neighbor walked. Add and a non-merging consume shift the tail up, one read
// and one write per moved entry; a consume that empties its entry shifts the
// tail down the same way. Worst case is a consume at the head of a table one
// short of full that neither merges nor leaves anything of its entry: it
// shifts the whole tail up and then back down.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_range_index_table #(
  parameter int ENTRIES = 256
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [7:0]  cfg_index_i,
  input  wire  [62:0] cfg_data_i,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [1:0]  func_i,
  input  wire  [62:0] key_offset_i,
  input  wire  [30:0] range_length_i,
  input  wire  [62:0] cache_offset_i,
  input  wire  [30:0] valid_bytes_i,
  input  wire  [7:0]  range_type_i,
  input  wire  [7:0]  entry_index_i,
  input  wire  [30:0] consume_length_i,
  input  wire  [62:0] lower_bound_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [1:0]  status_o,
  output logic        hit_o,
  output logic [7:0]  found_index_o,
  output logic [62:0] found_start_o,
  output logic [30:0] found_length_o,
  output logic [62:0] found_cache_offset_o,
  output logic signed [31:0] found_valid_o,
  output logic [7:0]  found_type_o,
  output logic [62:0] gap_start_o,
  output logic signed [31:0] gap_size_o
);

  localparam int AW = $clog2(ENTRIES);

  logic [62:0]      stream_size_q, stream_size_d;
  logic [7:0]       file_type_q, file_type_d;
  logic             out_valid_q, out_valid_d;
  srit_pkg::res_t   out_q, res;
  srit_pkg::req_t   req;
  logic             res_valid, res_ready;
  logic             mem_re, mem_we;
  logic [AW-1:0]    mem_raddr, mem_waddr;
  srit_pkg::entry_t mem_rdata, mem_wdata;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    stream_size_d = stream_size_q;
    file_type_d   = file_type_q;
    if (cfg_valid_i) begin
      if (cfg_index_i == srit_pkg::CFG_STREAM_SIZE) begin
        stream_size_d = cfg_data_i;
      end else if (cfg_index_i == srit_pkg::CFG_FILE_TYPE) begin
        file_type_d = cfg_data_i[7:0];
      end
    end
  end

  always_comb begin
    req.func           = func_i;
    req.key_offset     = key_offset_i;
    req.range_length   = range_length_i;
    req.cache_offset   = cache_offset_i;
    req.valid_bytes    = valid_bytes_i;
    req.range_type     = range_type_i;
    req.entry_index    = entry_index_i;
    req.consume_length = consume_length_i;
    req.lower_bound    = lower_bound_i;
  end

  srit_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_i         (req),
    .stream_size_i (stream_size_q),
    .file_type_i   (file_type_q),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .mem_re_o      (mem_re),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata)
  );

  srit_mem #(.ENTRIES(ENTRIES)) u_mem (
    .clk_i   (clk_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata)
  );

  // output word register
  assign res_ready   = !out_valid_q || out_ready_i;
  assign out_valid_d = (res_valid && res_ready) || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_size_q <= srit_pkg::STREAM_SIZE_RST;
      file_type_q   <= srit_pkg::FILE_TYPE_RST;
      out_valid_q   <= 1'b0;
    end else begin
      stream_size_q <= stream_size_d;
      file_type_q   <= file_type_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = out_q.status;
  assign hit_o                = out_q.hit;
  assign found_index_o        = out_q.found_index;
  assign found_start_o        = out_q.found_start;
  assign found_length_o       = out_q.found_length;
  assign found_cache_offset_o = out_q.found_cache_offset;
  assign found_valid_o        = out_q.found_valid;
  assign found_type_o         = out_q.found_type;
  assign gap_start_o          = out_q.gap_start;
  assign gap_size_o           = out_q.gap_size;

endmodule

`default_nettype wire

// ===== sim/sorted_range_index_table_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_range_index_table_tb
// Self-checking bench for the sorted range index table.
// Random and directed add/consume/find/gap words are sent through the
// valid/ready ports. A shadow copy of the table, kept in a small scoreboard
// class, predicts each result, and every returned word is compared field by
// field. The run covers an empty table, a full table, merges, removals and
// gap saturation, with several register settings.
// ----------------------------------------------------------------------------

module sorted_range_index_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import srit_pkg::*;

  localparam int NUM_ENTRIES = 256;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 600;

  class range_table_sb;
    logic [62:0] st[NUM_ENTRIES];
    logic [30:0] ln[NUM_ENTRIES];
    logic [62:0] ca[NUM_ENTRIES];
    logic [31:0] vl[NUM_ENTRIES];
    logic [7:0]  kd[NUM_ENTRIES];
    int          used;
    logic [62:0] stream_sz;
    logic [7:0]  file_kind;
    res_t        exp_q[$];
    int          errors;
    int          n_func[4];
    int          n_full;
    int          n_bad;
    int          n_merge;
    int          n_hit;

    function new();
      used = 0;
      stream_sz = STREAM_SIZE_RST;
      file_kind = FILE_TYPE_RST;
      errors = 0;
      n_full = 0;
      n_bad = 0;
      n_merge = 0;
      n_hit = 0;
      foreach (n_func[i]) n_func[i] = 0;
    endfunction

    function void set_reg(logic [7:0] idx, logic [62:0] data);
      if (idx == CFG_STREAM_SIZE) stream_sz = data;
      else if (idx == CFG_FILE_TYPE) file_kind = data[7:0];
    endfunction

    function int search(logic [62:0] key);
      int lo;
      int hi;
      int m;
      lo = -1;
      hi = used;
      while (hi - lo > 1) begin
        m = (lo + hi) / 2;
        if (st[m] <= key) lo = m;
        if (st[m] >= key) hi = m;
      end
      return lo;
    endfunction

    function void move_entry(int dst, int src);
      st[dst] = st[src];
      ln[dst] = ln[src];
      ca[dst] = ca[src];
      vl[dst] = vl[src];
      kd[dst] = kd[src];
    endfunction

    function void open_at(int pos);
      for (int i = used; i > pos; i--) move_entry(i, i - 1);
      used++;
    endfunction

    function void close_at(int pos);
      for (int i = pos; i + 1 < used; i++) move_entry(i, i + 1);
      used--;
    endfunction

    function logic [1:0] consume(int a, logic [30:0] rd, logic [62:0] coff);
      bit     merged;
      longint sd;
      longint cd;
      longint nl;
      longint rem;
      merged = 0;
      if (a >= used) return STATUS_BAD;
      if (a >= 1 && kd[a-1] == file_kind) begin
        sd = longint'({1'b0, st[a]}) - longint'({1'b0, st[a-1]});
        cd = longint'({1'b0, coff}) - longint'({1'b0, ca[a-1]});
        if (sd == cd && sd <= longint'(ln[a-1])) begin
          nl = sd + longint'(rd);
          if (nl < 0) nl = 0;
          if (nl > 64'h7fffffff) nl = 64'h7fffffff;
          ln[a-1] = nl[30:0];
          vl[a-1] = {1'b0, nl[30:0]};
          merged = 1;
          n_merge++;
        end
      end
      if (!merged) begin
        if (used >= NUM_ENTRIES) return STATUS_FULL;
        open_at(a);
        st[a] = st[a+1];
        ln[a] = rd;
        vl[a] = {1'b0, rd};
        ca[a] = coff;
        kd[a] = file_kind;
        a++;
      end
      st[a] = st[a] + 63'(rd);
      ca[a] = ca[a] + 63'(rd);
      vl[a] = vl[a] - 32'(rd);
      rem = longint'(ln[a]) - longint'(rd);
      if (rem <= 0) close_at(a);
      else ln[a] = rem[30:0];
      return STATUS_DONE;
    endfunction

    function void note_input(req_t r);
      res_t        e;
      int          a;
      longint unsigned gs;
      longint unsigned ge;
      longint unsigned d;
      longint      sz;
      e = '0;
      n_func[r.func]++;
      case (r.func)
        FUNC_ADD: begin
          if (used >= NUM_ENTRIES) begin
            e.status = STATUS_FULL;
          end else begin
            a = search(r.key_offset) + 1;
            open_at(a);
            st[a] = r.key_offset;
            ln[a] = r.range_length;
            ca[a] = r.cache_offset;
            vl[a] = {1'b0, r.valid_bytes};
            kd[a] = r.range_type;
          end
        end
        FUNC_CONSUME: begin
          e.status = consume(int'(r.entry_index), r.consume_length, r.cache_offset);
        end
        FUNC_FIND: begin
          a = search(r.key_offset);
          if (a >= 0 && a < used && st[a] <= r.key_offset &&
              64'(r.key_offset - st[a]) < 64'(ln[a])) begin
            e.hit = 1'b1;
            e.found_index = a[7:0];
            e.found_start = st[a];
            e.found_length = ln[a];
            e.found_cache_offset = ca[a];
            e.found_valid = vl[a];
            e.found_type = kd[a];
            n_hit++;
          end
        end
        default: begin
          a = search(r.key_offset);
          gs = 64'(r.lower_bound);
          ge = 64'(stream_sz);
          while (a >= 0 && a + 1 < used) begin
            if (64'(st[a]) + 64'(ln[a]) >= 64'(st[a+1])) a++;
            else break;
          end
          if (a >= 0 && a < used) begin
            if (64'(st[a]) + 64'(ln[a]) > gs) gs = 64'(st[a]) + 64'(ln[a]);
          end
          if (a >= 0 && a + 1 < used) ge = 64'(st[a+1]);
          if (ge >= gs) begin
            d = ge - gs;
            sz = (d > 64'h7fffffff) ? 64'sh7fffffff : longint'(d);
          end else begin
            d = gs - ge;
            sz = (d > 64'h80000000) ? -64'sh80000000 : -longint'(d);
          end
          e.gap_start = gs[62:0];
          e.gap_size = sz[31:0];
        end
      endcase
      if (e.status == STATUS_FULL) n_full++;
      if (e.status == STATUS_BAD) n_bad++;
      exp_q.push_back(e);
    endfunction

    function void check_result(res_t r);
      res_t e;
      if (exp_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      e = exp_q.pop_front();
      if (r.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, r.status); errors++;
      end
      if (r.hit !== e.hit) begin
        $error("hit exp %0d got %0d", e.hit, r.hit); errors++;
      end
      if (r.found_index !== e.found_index) begin
        $error("found_index exp %0d got %0d", e.found_index, r.found_index); errors++;
      end
      if (r.found_start !== e.found_start) begin
        $error("found_start exp %h got %h", e.found_start, r.found_start); errors++;
      end
      if (r.found_length !== e.found_length) begin
        $error("found_length exp %h got %h", e.found_length, r.found_length); errors++;
      end
      if (r.found_cache_offset !== e.found_cache_offset) begin
        $error("found_cache_offset exp %h got %h", e.found_cache_offset,
               r.found_cache_offset);
        errors++;
      end
      if (r.found_valid !== e.found_valid) begin
        $error("found_valid exp %h got %h", e.found_valid, r.found_valid); errors++;
      end
      if (r.found_type !== e.found_type) begin
        $error("found_type exp %h got %h", e.found_type, r.found_type); errors++;
      end
      if (r.gap_start !== e.gap_start) begin
        $error("gap_start exp %h got %h", e.gap_start, r.gap_start); errors++;
      end
      if (r.gap_size !== e.gap_size) begin
        $error("gap_size exp %h got %h", e.gap_size, r.gap_size); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [7:0]  cfg_index = '0;
  logic [62:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  req_t        req = '0;
  logic        out_ready = 1'b0;
  logic        cfg_ready;
  logic        in_ready;
  logic        out_valid;
  res_t        res;
  bit          calm = 1'b0;
  int          idle_cycles = 0;
  range_table_sb sb = new();

  always #5 clk_i = ~clk_i;

  sorted_range_index_table dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_o          (cfg_ready),
    .cfg_index_i          (cfg_index),
    .cfg_data_i           (cfg_data),
    .in_valid_i           (in_valid),
    .in_ready_o           (in_ready),
    .func_i               (req.func),
    .key_offset_i         (req.key_offset),
    .range_length_i       (req.range_length),
    .cache_offset_i       (req.cache_offset),
    .valid_bytes_i        (req.valid_bytes),
    .range_type_i         (req.range_type),
    .entry_index_i        (req.entry_index),
    .consume_length_i     (req.consume_length),
    .lower_bound_i        (req.lower_bound),
    .out_valid_o          (out_valid),
    .out_ready_i          (out_ready),
    .status_o             (res.status),
    .hit_o                (res.hit),
    .found_index_o        (res.found_index),
    .found_start_o        (res.found_start),
    .found_length_o       (res.found_length),
    .found_cache_offset_o (res.found_cache_offset),
    .found_valid_o        (res.found_valid),
    .found_type_o         (res.found_type),
    .gap_start_o          (res.gap_start),
    .gap_size_o           (res.gap_size)
  );

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) sb.check_result(res);
    out_ready <= calm || ($urandom_range(0, 99) >= 12);
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [62:0] rand63();
    return 63'({$urandom(), $urandom()});
  endfunction

  function automatic logic [30:0] rand_len();
    logic [30:0] v;
    v = 31'($urandom());
    return (v == 0) ? 31'd1 : v;
  endfunction

  // offset near an existing entry, or a plain small one
  function automatic logic [62:0] near_key();
    int i;
    if (sb.used == 0 || $urandom_range(0, 3) == 0) return 63'($urandom_range(0, 20000));
    i = $urandom_range(0, sb.used - 1);
    return sb.st[i] + 63'($urandom_range(0, (sb.ln[i] > 31'd500) ? 500 : int'(sb.ln[i])));
  endfunction

  function automatic req_t make_word(int add_pct);
    req_t r;
    int   sel;
    int   i;
    r = '0;
    r.func = FUNC_FIND;
    sel = $urandom_range(0, 99);
    if (sel < add_pct) r.func = FUNC_ADD;
    else if (sel < add_pct + (100 - add_pct) / 3) r.func = FUNC_CONSUME;
    else if (sel < add_pct + 2 * (100 - add_pct) / 3) r.func = FUNC_GAP;
    r.key_offset = ($urandom_range(0, 9) == 0) ? rand63() : near_key();
    r.range_length = ($urandom_range(0, 9) == 0) ? rand_len() : 31'($urandom_range(1, 400));
    r.cache_offset = ($urandom_range(0, 9) == 0) ? rand63() : 63'($urandom_range(0, 100000));
    r.valid_bytes = 31'($urandom());
    r.range_type = ($urandom_range(0, 1) == 0) ? sb.file_kind : 8'($urandom());
    r.entry_index = 8'($urandom());
    r.consume_length = ($urandom_range(0, 9) == 0) ? rand_len() : 31'($urandom_range(1, 400));
    r.lower_bound = ($urandom_range(0, 4) == 0) ? rand63() : 63'($urandom_range(0, 20000));
    if (r.func == FUNC_ADD && sb.used > 0 && $urandom_range(0, 2) == 0) begin
      i = $urandom_range(0, sb.used - 1);
      r.key_offset = sb.st[i] + 63'(sb.ln[i]);
    end
    if (r.func == FUNC_CONSUME && sb.used > 0 && $urandom_range(0, 9) != 0) begin
      i = $urandom_range(0, sb.used - 1);
      r.entry_index = i[7:0];
      if ($urandom_range(0, 3) != 0 && sb.ln[i] > 0)
        r.consume_length = 31'($urandom_range(1, (sb.ln[i] > 31'd600) ? 600
                                                                      : int'(sb.ln[i])));
      if (i >= 1 && $urandom_range(0, 4) < 3)
        r.cache_offset = sb.ca[i-1] + (sb.st[i] - sb.st[i-1]);
    end
    return r;
  endfunction

  // called at a rising edge; returns at the edge that takes the word
  task automatic send_word(req_t r);
    if (!calm && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    req <= r;
    do @(negedge clk_i); while (!in_ready);
    @(posedge clk_i);
    sb.note_input(r);
  endtask

  task automatic write_regs(logic [62:0] size_val, logic [7:0] kind_val);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_STREAM_SIZE;
    cfg_data <= size_val;
    do @(negedge clk_i); while (!cfg_ready);
    @(posedge clk_i);
    sb.set_reg(CFG_STREAM_SIZE, size_val);
    cfg_index <= CFG_FILE_TYPE;
    cfg_data <= 63'(kind_val);
    do @(negedge clk_i); while (!cfg_ready);
    @(posedge clk_i);
    sb.set_reg(CFG_FILE_TYPE, 63'(kind_val));
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.exp_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic req_t word(logic [1:0] f, logic [62:0] key, logic [30:0] len,
                                logic [62:0] coff, logic [7:0] kind, logic [7:0] idx,
                                logic [62:0] lb);
    req_t r;
    r = '0;
    r.func = f;
    r.key_offset = key;
    r.range_length = len;
    r.cache_offset = coff;
    r.valid_bytes = 31'(len);
    r.range_type = kind;
    r.entry_index = idx;
    r.consume_length = len;
    r.lower_bound = lb;
    return r;
  endfunction

  initial begin
    req_t dir[$];
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_regs(STREAM_SIZE_RST, FILE_TYPE_RST);

    // empty table, then merge, removal, extremes and saturation
    dir.push_back(word(FUNC_FIND, 0, 1, 0, 0, 0, 0));
    dir.push_back(word(FUNC_GAP, 0, 1, 0, 0, 0, 0));
    dir.push_back(word(FUNC_CONSUME, 0, 1, 0, 0, 0, 0));
    dir.push_back(word(FUNC_ADD, 100, 50, 1000, 1, 0, 0));
    dir.push_back(word(FUNC_ADD, 150, 50, 5000, 7, 0, 0));
    dir.push_back(word(FUNC_CONSUME, 0, 20, 1050, 0, 1, 0));
    dir.push_back(word(FUNC_FIND, 100, 1, 0, 0, 0, 0));
    dir.push_back(word(FUNC_FIND, 169, 1, 0, 0, 0, 0));
    dir.push_back(word(FUNC_FIND, 200, 1, 0, 0, 0, 0));
    dir.push_back(word(FUNC_GAP, 0, 1, 0, 0, 0, 0));
    dir.push_back(word(FUNC_CONSUME, 0, 400, 77, 0, 1, 0));
    dir.push_back(word(FUNC_ADD, 100, 5, 9, 3, 0, 0));
    dir.push_back(word(FUNC_ADD, '1, '1, '1, 8'hff, 0, 0));
    dir.push_back(word(FUNC_FIND, '1, 1, 0, 0, 0, 0));
    dir.push_back(word(FUNC_GAP, '1, 1, 0, 0, 0, '1));
    dir.push_back(word(FUNC_GAP, 0, 1, 0, 0, 0, '1));
    dir.push_back(word(FUNC_CONSUME, 0, '1, '1, 0, 8'hff, 0));
    dir.push_back(word(FUNC_CONSUME, 0, '1, '1, 0, 0, 0));
    dir.push_back(word(FUNC_FIND, 50, 1, 0, 0, 0, 0));
    dir.push_back(word(FUNC_GAP, 120, 1, 0, 0, 0, 0));
    foreach (dir[i]) send_word(dir[i]);

    repeat (400) send_word(make_word(35));
    drain();
    write_regs(63'd5000, 8'd0);
    calm = 1'b1;
    while (sb.used < NUM_ENTRIES) send_word(make_word(90));
    calm = 1'b0;
    repeat (150) send_word(make_word(45));
    drain();
    write_regs('1, 8'hff);
    repeat (100) send_word(make_word(30));
    drain();
    write_regs(63'd0, 8'd1);
    repeat (150) send_word(make_word(35));
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d adds, %0d consumes, %0d finds (%0d hits), %0d gap queries.",
             sb.n_func[FUNC_ADD], sb.n_func[FUNC_CONSUME], sb.n_func[FUNC_FIND],
             sb.n_hit, sb.n_func[FUNC_GAP]);
    $display("Table-full answers %0d, bad index %0d, merges %0d.",
             sb.n_full, sb.n_bad, sb.n_merge);
    if (sb.errors == 0 && sb.exp_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/srit_pkg.sv
hw/rtl/srit_mem.sv
hw/rtl/srit_ctrl.sv
hw/rtl/sorted_range_index_table.sv
sim/sorted_range_index_table_tb.sv
